// ===== rtl/core/rv64_subset_core_macros.svh =====
// Assertion macros shared by the rv64 subset core RTL.
`ifndef RV64_SUBSET_CORE_MACROS_SVH
`define RV64_SUBSET_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RVSC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define RVSC_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define RVSC_ASSERT(name, prop, msg)
`define RVSC_NEVER(name, cond, msg)
`endif

`endif

// ===== rtl/core/rvsc_pkg.sv =====
// Shared types, constants and helpers of the rv64 subset core.
package rvsc_pkg;

   localparam int unsigned XLEN           = 64;
   localparam int unsigned PC_W           = 32;
   localparam int unsigned INSTR_W        = 32;
   localparam int unsigned REQ_ADDR_W     = 10;
   localparam int unsigned NUM_REGS       = 32;
   localparam int unsigned REG_IDX_W      = 5;
   localparam int unsigned LANES          = 8;
   localparam int unsigned LANE_W         = 3;
   localparam int unsigned DATA_BYTES_DEF = 1024;

   localparam logic [6:0] OPC_RTYPE  = 7'b0110011;
   localparam logic [6:0] OPC_ADDI   = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_HALT   = 7'b1111111;
   localparam logic [6:0] F7_ADD     = 7'b0000000;
   localparam logic [6:0] F7_SUB     = 7'b0100000;
   localparam logic [2:0] F3_ADD_SUB = 3'b000;
   localparam logic [2:0] F3_AND     = 3'b111;
   localparam logic [2:0] F3_OR      = 3'b110;
   localparam logic [2:0] F3_XOR     = 3'b100;

   typedef enum logic [1:0] {
      CMD_EXEC      = 2'd0,
      CMD_WRITE_MEM = 2'd1,
      CMD_READ_REG  = 2'd2,
      CMD_READ_MEM  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [XLEN-1:0]      data;
   } rf_wr_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } dmem_cmd_type;

   typedef struct packed {
      logic                 wen;
      logic                 load;
      logic                 rd_reg;
      logic                 rd_mem;
      logic [REG_IDX_W-1:0] rd;
   } c_ctl_type;

   function automatic logic [XLEN-1:0] sext12(input logic [11:0] v);
      return {{(XLEN-12){v[11]}}, v};
   endfunction

endpackage

// ===== rtl/core/rvsc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rvsc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 128,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rvsc_regfile.sv =====
// Register file: two RAM copies for two read ports, valid bits and last-write bypass.
module rvsc_regfile import rvsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [REG_IDX_W-1:0] rd_idx_a,
   input  logic [REG_IDX_W-1:0] rd_idx_b,
   input  rf_wr_type            wr,
   output logic [XLEN-1:0]      rd_data_a,
   output logic [XLEN-1:0]      rd_data_b
);

   logic [NUM_REGS-1:0]  valid_ff;
   rf_wr_type            last_ff;
   logic [REG_IDX_W-1:0] idx_a_ff;
   logic [REG_IDX_W-1:0] idx_b_ff;
   logic                 valid_a_ff;
   logic                 valid_b_ff;
   logic [XLEN-1:0]      ram_a;
   logic [XLEN-1:0]      ram_b;

   rvsc_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.idx),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_a),
      .rd_data (ram_a)
   );

   rvsc_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.idx),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_b),
      .rd_data (ram_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         last_ff  <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
         last_ff          <= wr;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         idx_a_ff   <= rd_idx_a;
         idx_b_ff   <= rd_idx_b;
         valid_a_ff <= valid_ff[rd_idx_a];
         valid_b_ff <= valid_ff[rd_idx_b];
      end
   end

   always_comb begin
      if (idx_a_ff == '0) begin
         rd_data_a = '0;
      end else if (last_ff.en && last_ff.idx == idx_a_ff) begin
         rd_data_a = last_ff.data;
      end else begin
         rd_data_a = valid_a_ff ? ram_a : '0;
      end
      if (idx_b_ff == '0) begin
         rd_data_b = '0;
      end else if (last_ff.en && last_ff.idx == idx_b_ff) begin
         rd_data_b = last_ff.data;
      end else begin
         rd_data_b = valid_b_ff ? ram_b : '0;
      end
   end

endmodule

// ===== rtl/core/rvsc_dmem.sv =====
// Data memory: eight byte-lane RAM banks with doubleword steering and clear pass.
module rvsc_dmem import rvsc_pkg::*; #(
   parameter int unsigned DATA_BYTES = DATA_BYTES_DEF,
   localparam int unsigned AW        = $clog2(DATA_BYTES),
   localparam int unsigned ROWS      = DATA_BYTES / LANES,
   localparam int unsigned RW        = $clog2(ROWS)
) (
   input  logic            clock,
   input  logic            reset,
   input  dmem_cmd_type    cmd,
   input  logic [AW-1:0]   addr,
   input  logic [XLEN-1:0] wdata,
   output logic [XLEN-1:0] rdata,
   output logic            busy
);

   logic              clr_ff;
   logic [RW-1:0]     clr_row_ff;
   logic [LANE_W-1:0] lane_ff;
   logic [7:0]        bank_dout [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_row_ff <= '0;
      end else if (clr_ff) begin
         clr_row_ff <= clr_row_ff + 1'b1;
         if (clr_row_ff == RW'(ROWS - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         lane_ff <= addr[LANE_W-1:0];
      end
   end

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [LANE_W-1:0] k;
      logic [RW-1:0]     row;
      logic [7:0]        wr_octet;

      always_comb begin
         k        = LANE_W'(b) - addr[LANE_W-1:0];
         row      = addr[AW-1:LANE_W] + RW'(LANE_W'(b) < addr[LANE_W-1:0]);
         wr_octet = wdata[{~k, 3'b000} +: 8];
      end

      rvsc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
         .clock   (clock),
         .wr_en   (clr_ff || cmd.wr),
         .wr_addr (clr_ff ? clr_row_ff : row),
         .wr_data (clr_ff ? 8'd0 : wr_octet),
         .rd_en   (cmd.rd),
         .rd_addr (row),
         .rd_data (bank_dout[b])
      );
   end

   always_comb begin
      logic [LANE_W-1:0] sel;
      rdata = '0;
      for (int k = 0; k < LANES; k++) begin
         sel = lane_ff + LANE_W'(k);
         rdata[8*(LANES-1-k) +: 8] = bank_dout[sel];
      end
   end

   assign busy = clr_ff;

endmodule

// ===== rtl/core/rv64_subset_core.sv =====
// Top level of the rv64 subset core: handshake, decode, execute and result stages.
// One command is taken per transfer on req_*; its result passes through the b_*, c_* and
// rsp_* registers. A new command can be taken every cycle while rsp_ready is high, so the
// sustained rate is one item per clock. The execute stage sets that figure: it bypasses
// the result of the previous command (including a load, straight from the data banks)
// into its operands and drives the bank addresses in the same cycle. Registers live in
// two 32 x 64 RAM copies (one per source operand) and data in eight byte-wide banks of
// DATA_BYTES/8 rows, so any doubleword, aligned or not, is one access. After reset the
// banks are zeroed one row per cycle while req_ready stays low.
// DATA_BYTES must be a power of two.
`include "rv64_subset_core_macros.svh"

module rv64_subset_core import rvsc_pkg::*; #(
   parameter int unsigned DATA_BYTES = DATA_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [INSTR_W-1:0]    req_instr,
   input  logic [REQ_ADDR_W-1:0] req_addr,
   input  logic [XLEN-1:0]       req_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PC_W-1:0]       rsp_next_pc,
   output logic                  rsp_halted,
   output logic [XLEN-1:0]       rsp_rdata
);

   localparam int unsigned AW = $clog2(DATA_BYTES);

   logic                  rsp_valid_ff;
   logic [PC_W-1:0]       rsp_next_pc_ff;
   logic                  rsp_halted_ff;
   logic [XLEN-1:0]       rsp_rdata_ff;

   logic                  b_valid_ff;
   cmd_type               b_cmd_ff;
   logic [INSTR_W-1:0]    b_instr_ff;
   logic [REQ_ADDR_W-1:0] b_addr_ff;
   logic [XLEN-1:0]       b_wdata_ff;

   logic                  c_valid_ff;
   c_ctl_type             c_ctl_ff;
   c_ctl_type             c_ctl_in;
   logic [XLEN-1:0]       c_val_ff;
   logic [XLEN-1:0]       c_val_in;
   logic [PC_W-1:0]       c_pc_ff;
   logic                  c_halt_ff;

   logic [PC_W-1:0]       pc_ff;
   logic [PC_W-1:0]       pc_in;
   logic                  halt_ff;
   logic                  halt_in;

   logic                  out_free;
   logic                  c_free;
   logic                  c_move;
   logic                  b_free;
   logic                  b_move;
   logic                  req_fire;

   logic [REG_IDX_W-1:0]  rf_idx_a;
   logic [REG_IDX_W-1:0]  b_idx_a;
   logic [REG_IDX_W-1:0]  b_idx_b;
   logic [XLEN-1:0]       rf_a;
   logic [XLEN-1:0]       rf_b;
   logic [XLEN-1:0]       op_a;
   logic [XLEN-1:0]       op_b;
   logic [XLEN-1:0]       c_wval;
   rf_wr_type             rf_wr;

   dmem_cmd_type          dm_cmd;
   dmem_cmd_type          dm_req;
   logic [XLEN-1:0]       dm_addr_full;
   logic [XLEN-1:0]       dm_wdata;
   logic [XLEN-1:0]       dm_rdata;
   logic                  dm_busy;

   // handshake and stage advance
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign c_move    = c_valid_ff && out_free;
   assign c_free    = !c_valid_ff || out_free;
   assign b_move    = b_valid_ff && c_free;
   assign b_free    = !b_valid_ff || c_free;
   assign req_ready = b_free && !dm_busy;
   assign req_fire  = req_valid && req_ready;

   assign rf_idx_a = (cmd_type'(req_cmd) == CMD_READ_REG) ?
                     req_addr[REG_IDX_W-1:0] : req_instr[19:15];

   rvsc_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_idx_a  (rf_idx_a),
      .rd_idx_b  (req_instr[24:20]),
      .wr        (rf_wr),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   // bypass the command in the result stage
   assign b_idx_a = (b_cmd_ff == CMD_READ_REG) ? b_addr_ff[REG_IDX_W-1:0] : b_instr_ff[19:15];
   assign b_idx_b = b_instr_ff[24:20];
   assign c_wval  = c_ctl_ff.load ? dm_rdata : c_val_ff;
   assign op_a    = (c_valid_ff && c_ctl_ff.wen && c_ctl_ff.rd == b_idx_a) ? c_wval : rf_a;
   assign op_b    = (c_valid_ff && c_ctl_ff.wen && c_ctl_ff.rd == b_idx_b) ? c_wval : rf_b;

   always_comb begin
      logic [6:0]      opc;
      logic [2:0]      f3;
      logic [6:0]      f7;
      logic [PC_W-1:0] off_b;
      opc   = b_instr_ff[6:0];
      f3    = b_instr_ff[14:12];
      f7    = b_instr_ff[31:25];
      off_b = {{19{b_instr_ff[31]}}, b_instr_ff[31], b_instr_ff[7], b_instr_ff[30:25],
               b_instr_ff[11:8], 1'b0};
      c_ctl_in     = '0;
      c_val_in     = '0;
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      dm_cmd       = '0;
      dm_addr_full = {{(XLEN-REQ_ADDR_W){1'b0}}, b_addr_ff};
      dm_wdata     = b_wdata_ff;
      case (b_cmd_ff)
         CMD_EXEC: begin
            if (!halt_ff) begin
               pc_in = pc_ff + PC_W'(4);
               case (opc)
                  OPC_RTYPE: begin
                     c_ctl_in.wen = 1'b1;
                     if (f3 == F3_ADD_SUB && f7 == F7_ADD) begin
                        c_val_in = op_a + op_b;
                     end else if (f3 == F3_ADD_SUB && f7 == F7_SUB) begin
                        c_val_in = op_a - op_b;
                     end else if (f3 == F3_AND) begin
                        c_val_in = op_a & op_b;
                     end else if (f3 == F3_OR) begin
                        c_val_in = op_a | op_b;
                     end else if (f3 == F3_XOR) begin
                        c_val_in = op_a ^ op_b;
                     end else begin
                        c_ctl_in.wen = 1'b0;
                     end
                  end
                  OPC_ADDI: begin
                     c_ctl_in.wen = 1'b1;
                     c_val_in     = op_a + sext12(b_instr_ff[31:20]);
                  end
                  OPC_LOAD: begin
                     c_ctl_in.wen  = 1'b1;
                     c_ctl_in.load = 1'b1;
                     dm_cmd.rd     = 1'b1;
                     dm_addr_full  = op_a + sext12(b_instr_ff[31:20]);
                  end
                  OPC_STORE: begin
                     dm_cmd.wr    = 1'b1;
                     dm_addr_full = op_a + sext12({b_instr_ff[31:25], b_instr_ff[11:7]});
                     dm_wdata     = op_b;
                  end
                  OPC_BRANCH: begin
                     if (op_a == op_b) begin
                        pc_in = pc_ff + off_b;
                     end
                  end
                  OPC_HALT: begin
                     halt_in = 1'b1;
                     pc_in   = pc_ff;
                  end
                  default: ;
               endcase
            end
         end
         CMD_WRITE_MEM: dm_cmd.wr = 1'b1;
         CMD_READ_REG: begin
            c_ctl_in.rd_reg = 1'b1;
            c_val_in        = op_a;
         end
         CMD_READ_MEM: begin
            c_ctl_in.rd_mem = 1'b1;
            dm_cmd.rd       = 1'b1;
         end
         default: ;
      endcase
      c_ctl_in.rd  = b_instr_ff[11:7];
      c_ctl_in.wen = c_ctl_in.wen && (b_instr_ff[11:7] != '0);
   end

   assign dm_req.rd = dm_cmd.rd && b_move;
   assign dm_req.wr = dm_cmd.wr && b_move;

   rvsc_dmem #(.DATA_BYTES(DATA_BYTES)) u_dmem (
      .clock (clock),
      .reset (reset),
      .cmd   (dm_req),
      .addr  (dm_addr_full[AW-1:0]),
      .wdata (dm_wdata),
      .rdata (dm_rdata),
      .busy  (dm_busy)
   );

   assign rf_wr.en   = c_move && c_ctl_ff.wen;
   assign rf_wr.idx  = c_ctl_ff.rd;
   assign rf_wr.data = c_wval;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= c_valid_ff;
         end
         if (c_free) begin
            c_valid_ff <= b_valid_ff;
         end
         if (b_free) begin
            b_valid_ff <= req_fire;
         end
         if (b_move) begin
            pc_ff   <= pc_in;
            halt_ff <= halt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_cmd_ff   <= cmd_type'(req_cmd);
         b_instr_ff <= req_instr;
         b_addr_ff  <= req_addr;
         b_wdata_ff <= req_wdata;
      end
      if (b_move) begin
         c_ctl_ff  <= c_ctl_in;
         c_val_ff  <= c_val_in;
         c_pc_ff   <= pc_in;
         c_halt_ff <= halt_in;
      end
      if (c_move) begin
         rsp_next_pc_ff <= c_pc_ff;
         rsp_halted_ff  <= c_halt_ff;
         if (c_ctl_ff.rd_mem) begin
            rsp_rdata_ff <= dm_rdata;
         end else if (c_ctl_ff.rd_reg) begin
            rsp_rdata_ff <= c_val_ff;
         end else begin
            rsp_rdata_ff <= '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_next_pc = rsp_next_pc_ff;
   assign rsp_halted  = rsp_halted_ff;
   assign rsp_rdata   = rsp_rdata_ff;

   `RVSC_ASSERT(a_halt_sticky, halt_ff |=> halt_ff, "halt flag cleared")
   `RVSC_ASSERT(a_pc_hold, !b_move |=> $stable(pc_ff), "pc changed without execute advance")
   `RVSC_NEVER(a_no_x0_write, rf_wr.en && rf_wr.idx == '0, "register write to x0")
   `RVSC_NEVER(a_dmem_one_op, dm_req.rd && dm_req.wr, "data read and write in one cycle")

endmodule
